// ----- src/assert_macros.svh -----
// Assertion macros used by the execute core RTL.
// No dependencies; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- src/riec_pkg.sv -----
// Constants, opcodes and types of the execute core.
// No dependencies.
`default_nettype none
package riec_pkg;
	localparam int DATA_DEPTH  = 4096;
	localparam int IO_COUNT    = 22;
	localparam int INSTR_DEPTH = 1024;
	localparam int DATA_AW     = $clog2(DATA_DEPTH);
	localparam int IO_AW       = $clog2(IO_COUNT);
	localparam int PC_W        = $clog2(INSTR_DEPTH);
	localparam int IO_RETI     = 7;
	localparam int LINK_REG    = 15;
	localparam int FIFO_DEPTH  = 3;

	typedef enum logic [7:0] {
		OP_ADD = 8'd0, OP_SUB = 8'd1, OP_AND = 8'd2, OP_OR = 8'd3, OP_XOR = 8'd4,
		OP_MUL = 8'd5, OP_SLL = 8'd6, OP_SRA = 8'd7, OP_SRL = 8'd8,
		OP_BEQ = 8'd9, OP_BNE = 8'd10, OP_BLT = 8'd11, OP_BGT = 8'd12,
		OP_BLE = 8'd13, OP_BGE = 8'd14, OP_JAL = 8'd15, OP_LW = 8'd16,
		OP_SW = 8'd17, OP_RETI = 8'd18, OP_IN = 8'd19, OP_OUT = 8'd20,
		OP_HALT = 8'd21
	} opcode_t;

	typedef struct packed {
		logic [31:0]     value;
		logic            wrote;
		logic            taken;
		logic            halted;
		logic [PC_W-1:0] pc;
	} res_t;
endpackage
`default_nettype wire

// ----- src/riec_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module riec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ----- src/risc_instruction_execute_core_top.sv -----
// Channel | dir | tdata fields (low bit up)
// s_axis  | in  | instr_word[19:0], imm_word[31:20]
// m_axis  | out | next_fetch_address[9:0], halted[10], branch_taken[11],
//         |     | wrote_register[12], written_value[44:13]
// One instruction per cycle while ready is high; results pass the result stage and then the queue.
// A load finishes in the result stage through the data RAM port, forwarded to the next word.
// After reset a clearing pass writes DATA_DEPTH (4096) RAM words, one per cycle, ready low.
// A three-word output queue keeps input flowing while the output side stalls; ready drops
// once the queue and the result stage together hold three words.
// Top level of the execute core; depends on riec_pkg, riec_ram, assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none
module risc_instruction_execute_core_top import riec_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // instr_word, imm_word
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata   // next_fetch_address, halted, branch_taken,
	                                        // wrote_register, written_value
);
	logic [31:0]        rf_q [16];
	logic [31:0]        io_q [IO_COUNT];
	logic [PC_W-1:0]    pc_q;
	logic               halt_q;
	logic               clr_q;
	logic [DATA_AW-1:0] clr_cnt_q;

	logic               s1_valid;
	logic               s1_load;
	logic [3:0]         s1_rd;
	res_t               s1_res;

	res_t               fifo_q [FIFO_DEPTH];
	logic [1:0]         wr_ptr_q, rd_ptr_q, cnt_q;

	logic               ram_we;
	logic [DATA_AW-1:0] ram_addr;
	logic [31:0]        ram_wdata, ram_rdata;

	logic               acc;
	opcode_t            op;
	logic [3:0]         rd, rs, rt;
	logic [31:0]        imm, a, b, d, sum, val;
	logic [PC_W-1:0]    seq, nxt;
	logic               taken, writes, cond, mem_ok, io_ok, is_load;
	res_t               res, s1_out;
	logic               push, pop;
	logic               rf_we;
	logic [3:0]         rf_idx;

	function automatic logic [31:0] rdreg(input logic [3:0] idx, input logic [31:0] immv,
			input logic fwd, input logic [3:0] fidx, input logic [31:0] fdata,
			input logic [31:0] rfv);
		logic [31:0] r;
		if (idx == 4'd0) begin
			r = '0;
		end else if (idx == 4'd1) begin
			r = immv;
		end else if (fwd && idx == fidx) begin
			r = fdata;
		end else begin
			r = rfv;
		end
		return r;
	endfunction

	assign s_axis_tready = !clr_q && ({1'b0, cnt_q} + {2'b0, s1_valid} <= 3'd2);
	assign acc = s_axis_tvalid && s_axis_tready;

	assign op  = opcode_t'(s_axis_tdata[19:12]);
	assign rd  = s_axis_tdata[11:8];
	assign rs  = s_axis_tdata[7:4];
	assign rt  = s_axis_tdata[3:0];
	assign imm = {{20{s_axis_tdata[31]}}, s_axis_tdata[31:20]};

	assign a = rdreg(rs, imm, s1_valid && s1_load, s1_rd, ram_rdata, rf_q[rs]);
	assign b = rdreg(rt, imm, s1_valid && s1_load, s1_rd, ram_rdata, rf_q[rt]);
	assign d = rdreg(rd, imm, s1_valid && s1_load, s1_rd, ram_rdata, rf_q[rd]);
	assign sum    = a + b;
	assign mem_ok = sum < 32'(DATA_DEPTH);
	assign io_ok  = sum < 32'(IO_COUNT);
	assign seq    = pc_q + PC_W'(1) + ((rs == 4'd1 || rt == 4'd1) ? PC_W'(1) : PC_W'(0));

	always_comb begin
		val    = '0;
		writes = 1'b0;
		cond   = 1'b0;
		taken  = 1'b0;
		nxt    = seq;
		unique case (op)
			OP_ADD: begin val = a + b; writes = 1'b1; end
			OP_SUB: begin val = a - b; writes = 1'b1; end
			OP_AND: begin val = a & b; writes = 1'b1; end
			OP_OR:  begin val = a | b; writes = 1'b1; end
			OP_XOR: begin val = a ^ b; writes = 1'b1; end
			OP_MUL: begin val = a * b; writes = 1'b1; end
			OP_SLL: begin val = a << b[4:0]; writes = 1'b1; end
			OP_SRA: begin val = 32'($signed(a) >>> b[4:0]); writes = 1'b1; end
			OP_SRL: begin val = a >> b[4:0]; writes = 1'b1; end
			OP_BEQ: cond = (a == b);
			OP_BNE: cond = (a != b);
			OP_BLT: cond = $signed(a) < $signed(b);
			OP_BGT: cond = $signed(b) < $signed(a);
			OP_BLE: cond = !($signed(b) < $signed(a));
			OP_BGE: cond = !($signed(a) < $signed(b));
			OP_JAL: begin
				val    = 32'(seq);
				writes = 1'b1;
				nxt    = d[PC_W-1:0];
				taken  = 1'b1;
			end
			OP_RETI: begin
				nxt   = io_q[IO_RETI][PC_W-1:0];
				taken = 1'b1;
			end
			OP_IN: begin
				if (io_ok) begin
					val    = io_q[sum[IO_AW-1:0]];
					writes = 1'b1;
				end
			end
			OP_HALT: nxt = pc_q;
			default: ;
		endcase
		if (cond) begin
			nxt   = d[PC_W-1:0];
			taken = 1'b1;
		end
	end

	assign is_load = (op == OP_LW) && mem_ok && rd != 4'd0;

	assign rf_idx = (op == OP_JAL) ? 4'(LINK_REG) : rd;
	assign rf_we  = acc && !halt_q && ((op == OP_JAL) || (writes && rd != 4'd0));

	always_comb begin
		res.pc     = halt_q ? pc_q : nxt;
		res.halted = halt_q || op == OP_HALT;
		res.taken  = !halt_q && taken;
		res.wrote  = !halt_q && ((op == OP_JAL) || (writes && rd != 4'd0) || is_load);
		res.value  = (!halt_q && ((op == OP_JAL) || (writes && rd != 4'd0))) ? val : '0;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = sum[DATA_AW-1:0];
		ram_wdata = d;
		if (clr_q) begin
			ram_we    = 1'b1;
			ram_addr  = clr_cnt_q;
			ram_wdata = '0;
		end else if (acc && !halt_q && op == OP_SW && mem_ok) begin
			ram_we = 1'b1;
		end
	end

	riec_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_dmem (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + DATA_AW'(1);
			if (clr_cnt_q == DATA_AW'(DATA_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			halt_q   <= 1'b0;
			s1_valid <= 1'b0;
			s1_load  <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				rf_q[i] <= '0;
			end
			for (int i = 0; i < IO_COUNT; i++) begin
				io_q[i] <= '0;
			end
		end else begin
			s1_valid <= acc;
			s1_load  <= acc && !halt_q && is_load;
			if (s1_valid && s1_load && !(rf_we && rf_idx == s1_rd)) begin
				rf_q[s1_rd] <= ram_rdata;
			end
			if (rf_we) begin
				rf_q[rf_idx] <= val;
			end
			if (acc && !halt_q) begin
				pc_q <= nxt;
				if (op == OP_HALT) begin
					halt_q <= 1'b1;
				end
				if (op == OP_OUT && io_ok) begin
					io_q[sum[IO_AW-1:0]] <= d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_rd  <= rd;
			s1_res <= res;
		end
	end

	always_comb begin
		s1_out = s1_res;
		if (s1_load) begin
			s1_out.value = ram_rdata;
		end
	end

	assign push = s1_valid;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= s1_out;
		end
	end

	assign m_axis_tvalid = cnt_q != 2'd0;
	assign m_axis_tdata  = {3'b000, fifo_q[rd_ptr_q]};

	`ASSERT_IMPL(a_no_accept_in_clear, clk, arst_n, clr_q, !s_axis_tready)
	`ASSERT_NEXT(a_halt_sticks, clk, arst_n, halt_q, halt_q)
	`ASSERT_IMPL(a_queue_room, clk, arst_n, s1_valid && !pop, cnt_q < 2'(FIFO_DEPTH))
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for risc_instruction_execute_core_top: streams instructions
// with random gaps and stalls and predicts every result word in a scoreboard class.
// Depends on riec_pkg and the core RTL.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import riec_pkg::*;

	class core_predictor;
		bit [PC_W-1:0] pc;
		bit [31:0] regs[16];
		bit [31:0] dmem[DATA_DEPTH];
		bit [31:0] io_regs[IO_COUNT];
		bit stopped;
		res_t expected_results[$];
		int errors;

		function bit [31:0] read_reg(bit [3:0] idx, bit [31:0] immv);
			if (idx == 0) return 0;
			if (idx == 1) return immv;
			return regs[idx];
		endfunction

		function void note_instruction(bit [19:0] iw, bit [11:0] imm);
			bit [7:0] op;
			bit [3:0] rd, rs, rt;
			bit [31:0] immv, a, b, d, val, addr;
			bit [PC_W-1:0] seq, nxt;
			bit taken, wr, cond;
			res_t r;
			op = iw[19:12];
			rd = iw[11:8];
			rs = iw[7:4];
			rt = iw[3:0];
			r = '0;
			if (stopped) begin
				r.pc = pc;
				r.halted = 1'b1;
				expected_results.push_back(r);
				return;
			end
			immv = {{20{imm[11]}}, imm};
			a = read_reg(rs, immv);
			b = read_reg(rt, immv);
			d = read_reg(rd, immv);
			seq = pc + PC_W'(1) + ((rs == 4'd1 || rt == 4'd1) ? PC_W'(1) : PC_W'(0));
			nxt = seq;
			addr = a + b;
			val = 0;
			taken = 0;
			wr = 0;
			cond = 0;
			case (op)
				OP_ADD: begin val = a + b; wr = 1; end
				OP_SUB: begin val = a - b; wr = 1; end
				OP_AND: begin val = a & b; wr = 1; end
				OP_OR:  begin val = a | b; wr = 1; end
				OP_XOR: begin val = a ^ b; wr = 1; end
				OP_MUL: begin val = a * b; wr = 1; end
				OP_SLL: begin val = a << b[4:0]; wr = 1; end
				OP_SRA: begin val = $signed(a) >>> b[4:0]; wr = 1; end
				OP_SRL: begin val = a >> b[4:0]; wr = 1; end
				OP_BEQ: cond = (a == b);
				OP_BNE: cond = (a != b);
				OP_BLT: cond = $signed(a) < $signed(b);
				OP_BGT: cond = $signed(b) < $signed(a);
				OP_BLE: cond = !($signed(b) < $signed(a));
				OP_BGE: cond = !($signed(a) < $signed(b));
				OP_JAL: begin
					regs[LINK_REG] = 32'(seq);
					val = 32'(seq);
					wr = 1;
					rd = 4'(LINK_REG);
					nxt = d[PC_W-1:0];
					taken = 1;
				end
				OP_LW: if (addr < DATA_DEPTH) begin
					val = dmem[addr[DATA_AW-1:0]];
					wr = 1;
				end
				OP_SW: if (addr < DATA_DEPTH) dmem[addr[DATA_AW-1:0]] = d;
				OP_RETI: begin nxt = io_regs[IO_RETI][PC_W-1:0]; taken = 1; end
				OP_IN: if (addr < IO_COUNT) begin val = io_regs[addr[IO_AW-1:0]]; wr = 1; end
				OP_OUT: if (addr < IO_COUNT) io_regs[addr[IO_AW-1:0]] = d;
				OP_HALT: begin stopped = 1; nxt = pc; end
				default: ;
			endcase
			if (op >= OP_BEQ && op <= OP_BGE && cond) begin
				nxt = d[PC_W-1:0];
				taken = 1;
			end
			if (wr && rd != 0) regs[rd] = val;
			else begin
				wr = 0;
				val = 0;
			end
			pc = nxt;
			r.pc = pc;
			r.halted = stopped;
			r.taken = taken;
			r.wrote = wr;
			r.value = val;
			expected_results.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			e = expected_results.pop_front();
			if (got.pc !== e.pc) begin
				$display("%0t: next_fetch_address expected %0d actual %0d", $time, e.pc, got.pc);
				errors++;
			end
			if (got.halted !== e.halted) begin
				$display("%0t: halted expected %0b actual %0b", $time, e.halted, got.halted);
				errors++;
			end
			if (got.taken !== e.taken) begin
				$display("%0t: branch_taken expected %0b actual %0b", $time, e.taken, got.taken);
				errors++;
			end
			if (got.wrote !== e.wrote) begin
				$display("%0t: wrote_register expected %0b actual %0b", $time, e.wrote, got.wrote);
				errors++;
			end
			if (got.value !== e.value) begin
				$display("%0t: written_value expected %h actual %h", $time, e.value, got.value);
				errors++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // instr_word[19:0], imm_word[31:20]
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [47:0] m_axis_tdata;       // pc[9:0], halted, taken, wrote, value[44:13]

	core_predictor model = new();
	int tx_max = 0;
	int rx_max = 0;
	bit hold_req = 0;

	risc_instruction_execute_core_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) model.check_result(res_t'(m_axis_tdata[44:0]));
	end

	initial begin
		int n;
		forever begin
			if (hold_req) begin
				hold_req = 0;
				m_axis_tready = 0;
				repeat (300) @(negedge clk);
			end
			n = $urandom_range(0, rx_max);
			if (n > 0) begin
				m_axis_tready = 0;
				repeat (n) @(negedge clk);
			end
			m_axis_tready = 1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	function automatic bit [19:0] enc(bit [7:0] op, bit [3:0] rd, bit [3:0] rs, bit [3:0] rt);
		return {op, rd, rs, rt};
	endfunction

	task automatic send(input bit [19:0] iw, input bit [11:0] imm);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			s_axis_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tdata = {imm, iw};
		do @(posedge clk); while (!s_axis_tready);
		model.note_instruction(iw, imm);
		@(negedge clk);
	endtask

	task automatic send_random();
		int kind;
		bit [7:0] op;
		bit [3:0] rd, rs, rt;
		bit [11:0] imm;
		kind = $urandom_range(0, 99);
		rd = 4'($urandom_range(0, 15));
		rs = 4'($urandom_range(0, 15));
		rt = 4'($urandom_range(0, 15));
		imm = 12'($urandom);
		if (kind < 40) op = 8'($urandom_range(OP_ADD, OP_SRL));
		else if (kind < 60) op = 8'($urandom_range(OP_BEQ, OP_BGE));
		else if (kind < 88) begin
			op = 8'($urandom_range(OP_LW, OP_SW));
			if (kind >= 80) op = 8'($urandom_range(OP_IN, OP_OUT));
			case ($urandom_range(0, 4))
				0: begin rs = 1; rt = 0; end
				1: begin rs = 0; rt = 1; end
				2: begin rs = 1; rt = 1; end
				3: begin rs = 1; rt = 4'($urandom_range(0, 15)); end
				default: ;
			endcase
			if (op >= OP_IN) imm = 12'($urandom_range(0, 25) >> (rs == 1 && rt == 1));
		end else if (kind < 94) op = $urandom_range(0, 1) ? OP_JAL : OP_RETI;
		else op = 8'($urandom_range(OP_HALT + 1, 255));
		send(enc(op, rd, rs, rt), imm);
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1;
		send(enc(OP_ADD, 2, 1, 0), 12'h7FF);
		send(enc(OP_ADD, 3, 1, 0), 12'h800);
		send(enc(OP_SLL, 5, 1, 1), 12'h01F);
		send(enc(OP_SUB, 6, 5, 1), 12'h001);
		send(enc(OP_ADD, 7, 6, 1), 12'h001);
		send(enc(OP_MUL, 8, 6, 6), 12'h000);
		send(enc(OP_AND, 9, 6, 3), 12'h000);
		send(enc(OP_OR, 10, 6, 3), 12'h000);
		send(enc(OP_XOR, 11, 5, 3), 12'h000);
		send(enc(OP_SRA, 12, 5, 1), 12'hFE4);
		send(enc(OP_SRL, 13, 5, 1), 12'hFE4);
		send(enc(OP_BEQ, 2, 0, 0), 12'h000);
		send(enc(OP_BNE, 2, 0, 0), 12'h000);
		send(enc(OP_BLT, 2, 5, 6), 12'h000);
		send(enc(OP_BGT, 2, 5, 6), 12'h000);
		send(enc(OP_BLE, 2, 6, 6), 12'h000);
		send(enc(OP_BGE, 2, 5, 6), 12'h000);
		send(enc(OP_JAL, 1, 0, 0), 12'h155);
		send(enc(OP_SW, 2, 1, 1), 12'h7FF);
		send(enc(OP_LW, 4, 1, 1), 12'h7FF);
		send(enc(OP_LW, 4, 5, 0), 12'h000);
		send(enc(OP_OUT, 2, 1, 0), 12'h007);
		send(enc(OP_OUT, 6, 1, 0), 12'h00E);
		send(enc(OP_IN, 9, 1, 0), 12'h016);
		send(enc(OP_RETI, 0, 0, 0), 12'h000);
		send(enc(OP_ADD, 0, 1, 1), 12'h123);
		send(enc(8'hFF, 15, 15, 15), 12'hFFF);
		for (int i = 0; i < 1200; i++) begin
			if (i % 150 == 0) begin
				case ($urandom_range(0, 2))
					0: tx_max = 0;
					1: tx_max = 3;
					default: tx_max = 13;
				endcase
				case ($urandom_range(0, 2))
					0: rx_max = 0;
					1: rx_max = 3;
					default: rx_max = 13;
				endcase
			end
			if (i == 400) begin
				tx_max = 0;
				hold_req = 1;
			end
			if (i == 700) begin
				s_axis_tvalid = 0;
				while (model.pending() != 0) @(negedge clk);
			end
			send_random();
		end
		send(enc(OP_HALT, 0, 0, 0), 12'h000);
		send(enc(OP_ADD, 2, 1, 1), 12'h3FF);
		send(enc(OP_JAL, 2, 0, 0), 12'h000);
		s_axis_tvalid = 0;
		while (model.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (model.errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
